FILE: sv/minute_schedule_bitmap_assert.svh
// ----------------------------------------------------------------------------
// minute_schedule_bitmap assertion macros
// Shared assertion forms for the schedule bitmap design.
// ----------------------------------------------------------------------------
`ifndef MINUTE_SCHEDULE_BITMAP_ASSERT_SVH
`define MINUTE_SCHEDULE_BITMAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSBM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("minute_schedule_bitmap: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSBM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("minute_schedule_bitmap: next-cycle check failed");

`endif

FILE: sv/msbm_pkg.sv
// ----------------------------------------------------------------------------
// msbm_pkg
// Types and constants shared by the minute schedule bitmap modules.
// ----------------------------------------------------------------------------
package msbm_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int DAY_MINUTES   = 1440;
  localparam int MINUTE_W      = 11;
  localparam int HOURS_MAX     = 23;
  localparam int MINUTES_MAX   = 59;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TEST  = 2'd2
  } action_t;

endpackage

FILE: sv/msbm_store.sv
// ----------------------------------------------------------------------------
// msbm_store
// Schedule word memory with one read and one write port. The read data is
// registered. Words never written since reset read as zero.
// ----------------------------------------------------------------------------
module msbm_store #(
  parameter int WORD_BITS = msbm_pkg::WORD_BITS_DEF,
  localparam int NUM_WORDS = (msbm_pkg::DAY_MINUTES + WORD_BITS - 1) / WORD_BITS,
  localparam int ADDR_W = $clog2(NUM_WORDS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_raw;
  logic [NUM_WORDS-1:0] written;
  logic                 rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // One flag per word stands in for clearing the whole array at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_raw : '0;

endmodule

FILE: sv/minute_schedule_bitmap.sv
// ----------------------------------------------------------------------------
// minute_schedule_bitmap
// Every action walks all 45 words of the schedule memory, one word per cycle,
// writing back on writes; a new transaction waits until the answer is registered.
// Reset clears control state and marks every word unwritten, so the whole
// day reads as clear; the block takes a transaction in the cycle after reset.
// ----------------------------------------------------------------------------
`include "minute_schedule_bitmap_assert.svh"

module minute_schedule_bitmap #(
  parameter int WORD_BITS = msbm_pkg::WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [4:0] start_hour,
  input  logic [5:0] start_minute,
  input  logic [4:0] end_hour,
  input  logic [5:0] end_minute,
  input  logic       flag_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       answer
);

  localparam int NUM_WORDS = (msbm_pkg::DAY_MINUTES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = $clog2(NUM_WORDS);
  localparam int MW        = msbm_pkg::MINUTE_W;
  localparam int SH_W      = $clog2(WORD_BITS);
  localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(NUM_WORDS - 1);
  localparam logic [WORD_BITS-1:0] ONES      = '1;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_HOLD} state_t;

  state_t               state;
  msbm_pkg::action_t    act;
  logic [MW-1:0]        lo;
  logic [MW-1:0]        hi;
  logic                 pick;
  logic                 acc;
  logic                 acc_next;
  logic                 issuing;
  logic                 d_valid;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    d_addr;
  logic [MW-1:0]        base;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] ge_lo;
  logic [WORD_BITS-1:0] le_hi;
  logic [WORD_BITS-1:0] le_lo;
  logic [WORD_BITS-1:0] span;
  logic                 rd_en;
  logic                 wr_en;
  logic                 accept;

  // Saturate the fields, then form hour*60 + minute as (h<<6) - (h<<2) + m.
  function automatic logic [MW-1:0] minute_of(input logic [4:0] h, input logic [5:0] m);
    logic [4:0]    hs;
    logic [5:0]    ms;
    logic [MW-1:0] hw;
    hs = (h > 5'(msbm_pkg::HOURS_MAX)) ? 5'(msbm_pkg::HOURS_MAX) : h;
    ms = (m > 6'(msbm_pkg::MINUTES_MAX)) ? 6'(msbm_pkg::MINUTES_MAX) : m;
    hw = MW'(hs);
    return (hw << 6) - (hw << 2) + MW'(ms);
  endfunction

  // Bits of the word at minute base whose minute is at or after bound.
  function automatic logic [WORD_BITS-1:0] mask_ge(input logic [MW-1:0] bound,
                                                   input logic [MW-1:0] wbase);
    logic [MW:0] diff;
    diff = {1'b0, bound} - {1'b0, wbase};
    if (diff[MW]) begin
      return ONES;
    end else if (diff[MW-1:0] >= MW'(WORD_BITS)) begin
      return '0;
    end
    return ONES >> diff[SH_W-1:0];
  endfunction

  // Bits of the word at minute base whose minute is at or before bound.
  function automatic logic [WORD_BITS-1:0] mask_le(input logic [MW-1:0] bound,
                                                   input logic [MW-1:0] wbase);
    logic [MW:0]     diff;
    logic [SH_W-1:0] sh;
    diff = {1'b0, bound} - {1'b0, wbase};
    sh = diff[SH_W-1:0] + SH_W'(1);
    if (diff[MW]) begin
      return '0;
    end else if (diff[MW-1:0] >= MW'(WORD_BITS - 1)) begin
      return ONES;
    end
    return ~(ONES >> sh);
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_en    = (state == S_WALK) && issuing;
  assign wr_en    = (state == S_WALK) && d_valid && (act == msbm_pkg::ACT_WRITE);

  always_comb begin
    ge_lo = mask_ge(lo, base);
    le_hi = mask_le(hi, base);
    le_lo = mask_le(lo, base);
    span  = '0;
    case (act)
      msbm_pkg::ACT_WRITE: begin
        // A start later than the end wraps through midnight.
        span = (lo <= hi) ? (ge_lo & le_hi) : (ge_lo | le_hi);
      end
      msbm_pkg::ACT_READ: begin
        span = ge_lo & le_lo;
      end
      msbm_pkg::ACT_TEST: begin
        span = (lo <= hi) ? (ge_lo & le_hi) : '0;
      end
      default: begin
        span = '0;
      end
    endcase
    wr_data  = pick ? (rd_data | span) : (rd_data & ~span);
    acc_next = acc;
    case (act)
      msbm_pkg::ACT_READ: begin
        acc_next = acc | (|(rd_data & span));
      end
      msbm_pkg::ACT_TEST: begin
        acc_next = acc & ~(|((rd_data ^ {WORD_BITS{pick}}) & span));
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issuing   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The hold state sets out_valid itself, so the clear is left to the others.
      if (out_valid && out_ready && (state != S_HOLD)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            act     <= msbm_pkg::action_t'(action);
            lo      <= minute_of(start_hour, start_minute);
            hi      <= minute_of(end_hour, end_minute);
            pick    <= flag_value;
            acc     <= (msbm_pkg::action_t'(action) == msbm_pkg::ACT_TEST);
            rd_addr <= '0;
            base    <= '0;
            issuing <= 1'b1;
            d_valid <= 1'b0;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          d_valid <= issuing;
          d_addr  <= rd_addr;
          if (issuing) begin
            if (rd_addr == LAST_ADDR) begin
              issuing <= 1'b0;
            end else begin
              rd_addr <= rd_addr + ADDR_W'(1);
            end
          end
          if (d_valid) begin
            acc  <= acc_next;
            base <= base + MW'(WORD_BITS);
            if (d_addr == LAST_ADDR) begin
              state <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            answer    <= (act == msbm_pkg::ACT_WRITE) ? 1'b0 : acc;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  msbm_store #(
    .WORD_BITS(WORD_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (d_addr),
    .wr_data (wr_data)
  );

  // The write-back always trails the read by one word, so they never collide.
  `MSBM_ASSERT_SAME(a_no_collide, clk, rst, wr_en && rd_en, d_addr != rd_addr)
  `MSBM_ASSERT_SAME(a_addr_range, clk, rst, rd_en, rd_addr <= LAST_ADDR)
  `MSBM_ASSERT_NEXT(a_walk_start, clk, rst, accept, rd_en && (rd_addr == '0))
  `MSBM_ASSERT_SAME(a_write_only, clk, rst, wr_en, act == msbm_pkg::ACT_WRITE)

endmodule
